[design/gift_wrap_convex_hull_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the gift-wrap convex hull unit
// Clocked implication checks, disabled while reset is held.
// ---------------------------------------------------------------------------
`ifndef GIFT_WRAP_CONVEX_HULL_UNIT_ASSERT_SVH
`define GIFT_WRAP_CONVEX_HULL_UNIT_ASSERT_SVH

// same-cycle implication
`define GWCH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gift wrap hull check failed");

// next-cycle implication
`define GWCH_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gift wrap hull check failed");

`endif

[design/gwch_pkg.sv]
// ---------------------------------------------------------------------------
// Gift-wrap convex hull package
// Sizes, point and turn-test types shared by the hull unit's modules.
// ---------------------------------------------------------------------------
package gwch_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    point_t o;
    point_t p;
    point_t q;
  } turn_req_t;

  typedef struct packed {
    logic done;
    logic take;
  } turn_rsp_t;

  function automatic logic [DIFF_W-1:0] diff_mag(input diff_t v);
    logic [DIFF_W-1:0] r;
    r = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    return r;
  endfunction

endpackage

[design/gwch_point_mem.sv]
// ---------------------------------------------------------------------------
// Point store
// One write port, one registered read port with read enable.
// ---------------------------------------------------------------------------
module gwch_point_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [gwch_pkg::IDX_W-1:0] wr_addr,
  input  gwch_pkg::point_t          wr_data,
  input  logic                      rd_en,
  input  logic [gwch_pkg::IDX_W-1:0] rd_addr,
  output gwch_pkg::point_t          rd_data
);
  import gwch_pkg::*;

  point_t mem [MAX_POINTS];
  point_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/gwch_turn_unit.sv]
// ---------------------------------------------------------------------------
// Turn test unit
// Cross-product sign of (p - o) x (q - o) with one shared multiplier for both
// products, plus the collinear farther-point tie break.
// ---------------------------------------------------------------------------
module gwch_turn_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  gwch_pkg::turn_req_t  req,
  output gwch_pkg::turn_rsp_t  rsp
);
  import gwch_pkg::*;

  typedef enum logic [1:0] {U_IDLE, U_MUL1, U_MUL2, U_CMP} ustate_t;

  ustate_t state_r;
  diff_t   ax_r, ay_r, bx_r, by_r;
  prod_t   prod1_r, prod2_r;
  logic    far_r;

  diff_t   ax_nxt, ay_nxt, bx_nxt, by_nxt;
  diff_t   mul_a, mul_b;
  prod_t   mul_p;
  logic    far_nxt;
  logic [DIFF_W-1:0] pdx, qdx, pdy, qdy;

  assign ax_nxt = {req.p.x[COORD_BITS-1], req.p.x} - {req.o.x[COORD_BITS-1], req.o.x};
  assign ay_nxt = {req.p.y[COORD_BITS-1], req.p.y} - {req.o.y[COORD_BITS-1], req.o.y};
  assign bx_nxt = {req.q.x[COORD_BITS-1], req.q.x} - {req.o.x[COORD_BITS-1], req.o.x};
  assign by_nxt = {req.q.y[COORD_BITS-1], req.q.y} - {req.o.y[COORD_BITS-1], req.o.y};

  assign mul_a = (state_r == U_MUL1) ? ax_r : ay_r;
  assign mul_b = (state_r == U_MUL1) ? by_r : bx_r;
  assign mul_p = mul_a * mul_b;

  assign pdx = diff_mag(ax_r);
  assign qdx = diff_mag(bx_r);
  assign pdy = diff_mag(ay_r);
  assign qdy = diff_mag(by_r);
  assign far_nxt = (pdx != qdx) ? (pdx > qdx) : (pdy > qdy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
    end else begin
      unique case (state_r)
        U_IDLE: begin
          if (start) begin
            ax_r    <= ax_nxt;
            ay_r    <= ay_nxt;
            bx_r    <= bx_nxt;
            by_r    <= by_nxt;
            state_r <= U_MUL1;
          end
        end
        U_MUL1: begin
          prod1_r <= mul_p;
          far_r   <= far_nxt;
          state_r <= U_MUL2;
        end
        U_MUL2: begin
          prod2_r <= mul_p;
          state_r <= U_CMP;
        end
        U_CMP: begin
          state_r <= U_IDLE;
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

  assign rsp.done = (state_r == U_CMP);
  assign rsp.take = (prod1_r > prod2_r) || ((prod1_r == prod2_r) && far_r);

endmodule

[design/gift_wrap_convex_hull_unit.sv]
// ---------------------------------------------------------------------------
// Gift-wrap convex hull unit
// Loads a point set, then walks the hull and emits its vertices.
// ---------------------------------------------------------------------------
// Input channel (in_*): one point per beat, in_point_last closes the set.
// Points are taken at one per cycle while the set loads; up to MAX_POINTS
// are stored, later ones are dropped and flagged on out_points_dropped.
// Result channel (out_*): hull vertices counterclockwise from the leftmost
// (lowest y on equal x), out_hull_last on the final vertex.
// After the closing beat in_ready stays low for the walk: a leftmost search,
// then per vertex a scan for the first distinct point and a turn scan over
// all stored points; in the turn scan each point needs a store read and
// two products through the one shared multiplier.
// A vertex sits in the output register until taken; a stall holds the walk
// when its next vertex is ready, and the next set may load once the last
// vertex is registered. Reset empties the set and drops any pending vertex.
// ---------------------------------------------------------------------------
module gift_wrap_convex_hull_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gwch_pkg::coord_t in_point_x,
  input  gwch_pkg::coord_t in_point_y,
  input  logic             in_point_last,
  output logic             out_valid,
  input  logic             out_ready,
  output gwch_pkg::coord_t out_hull_x,
  output gwch_pkg::coord_t out_hull_y,
  output logic             out_hull_last,
  output logic             out_points_dropped
);
  import gwch_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_LM_RD, S_LM_CHK, S_VTX, S_FS_RD, S_FS_CHK,
    S_TS_RD, S_TS_GO, S_TS_WAIT, S_EMIT
  } state_t;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_POINTS);

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r, idx_r, emit_cnt_r;
  logic             ovf_r, fin_r;
  point_t           start_r, cur_r, cand_r;
  logic             out_valid_r, out_last_r, out_drop_r;
  coord_t           out_x_r, out_y_r;

  logic             in_acc, wr_en, rd_en, idx_done, lm_better, emit_go;
  logic [CNT_W-1:0] idx_inc, emit_inc;
  point_t           wr_data, rd_data, cand_nxt;
  turn_req_t        turn_req;
  turn_rsp_t        turn_rsp;

  assign in_ready  = (state_r == S_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign wr_en     = in_acc && (cnt_r != CNT_FULL);
  assign wr_data   = '{x: in_point_x, y: in_point_y};
  assign rd_en     = (state_r == S_LM_RD) || (state_r == S_FS_RD) || (state_r == S_TS_RD);
  assign idx_inc   = idx_r + CNT_W'(1);
  assign idx_done  = (idx_inc == cnt_r);
  assign emit_inc  = emit_cnt_r + CNT_W'(1);
  assign lm_better = ($signed(rd_data.x) < $signed(start_r.x)) ||
                     (($signed(rd_data.x) == $signed(start_r.x)) &&
                      ($signed(rd_data.y) < $signed(start_r.y)));
  assign cand_nxt  = turn_rsp.take ? rd_data : cand_r;
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  assign turn_req  = '{o: cur_r, p: rd_data, q: cand_r};

  gwch_point_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  gwch_turn_unit u_turn (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_TS_GO),
    .req   (turn_req),
    .rsp   (turn_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      emit_cnt_r  <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
        out_x_r     <= cur_r.x;
        out_y_r     <= cur_r.y;
        out_last_r  <= fin_r;
        out_drop_r  <= ovf_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (cnt_r != CNT_FULL) begin
              cnt_r <= cnt_r + CNT_W'(1);
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_point_last) begin
              idx_r   <= '0;
              state_r <= S_LM_RD;
            end
          end
        end
        S_LM_RD: state_r <= S_LM_CHK;
        S_LM_CHK: begin
          if ((idx_r == '0) || lm_better) begin
            start_r <= rd_data;
          end
          if (idx_done) begin
            cur_r      <= ((idx_r == '0) || lm_better) ? rd_data : start_r;
            emit_cnt_r <= '0;
            state_r    <= S_VTX;
          end else begin
            idx_r   <= idx_inc;
            state_r <= S_LM_RD;
          end
        end
        S_VTX: begin
          emit_cnt_r <= emit_inc;
          idx_r      <= '0;
          if (emit_inc >= cnt_r) begin
            fin_r   <= 1'b1;
            state_r <= S_EMIT;
          end else begin
            fin_r   <= 1'b0;
            state_r <= S_FS_RD;
          end
        end
        S_FS_RD: state_r <= S_FS_CHK;
        S_FS_CHK: begin
          if (rd_data != cur_r) begin
            cand_r  <= rd_data;
            idx_r   <= '0;
            state_r <= S_TS_RD;
          end else if (idx_done) begin
            fin_r   <= 1'b1;
            state_r <= S_EMIT;
          end else begin
            idx_r   <= idx_inc;
            state_r <= S_FS_RD;
          end
        end
        S_TS_RD: state_r <= S_TS_GO;
        S_TS_GO: state_r <= S_TS_WAIT;
        S_TS_WAIT: begin
          if (turn_rsp.done) begin
            cand_r <= cand_nxt;
            if (idx_done) begin
              fin_r   <= (cand_nxt == start_r);
              state_r <= S_EMIT;
            end else begin
              idx_r   <= idx_inc;
              state_r <= S_TS_RD;
            end
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            if (fin_r) begin
              cnt_r   <= '0;
              ovf_r   <= 1'b0;
              state_r <= S_LOAD;
            end else begin
              cur_r   <= cand_r;
              state_r <= S_VTX;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hull_x         = out_x_r;
  assign out_hull_y         = out_y_r;
  assign out_hull_last      = out_last_r;
  assign out_points_dropped = out_drop_r;

endmodule

[design/gwch_chk.sv]
// ---------------------------------------------------------------------------
// Gift-wrap convex hull port checker
// Watches the hull unit's channels over time; bound to the top level.
// ---------------------------------------------------------------------------
`include "gift_wrap_convex_hull_unit_assert.svh"

module gwch_chk (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input gwch_pkg::coord_t in_point_x,
  input gwch_pkg::coord_t in_point_y,
  input logic             in_point_last,
  input logic             out_valid,
  input logic             out_ready,
  input gwch_pkg::coord_t out_hull_x,
  input gwch_pkg::coord_t out_hull_y,
  input logic             out_hull_last,
  input logic             out_points_dropped
);
  import gwch_pkg::*;

  logic [2*COORD_BITS:0]   in_beat;
  logic [2*COORD_BITS+1:0] out_beat;

  assign in_beat  = {in_point_x, in_point_y, in_point_last};
  assign out_beat = {out_hull_x, out_hull_y, out_hull_last, out_points_dropped};

  // a waiting point beat holds
  `GWCH_ASSERT_NXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_beat))
  // a stalled vertex holds
  `GWCH_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_beat))
  // closing beat starts the walk
  `GWCH_ASSERT_NXT(a_walk_starts, in_valid && in_ready && in_point_last, !in_ready)
  // open set keeps loading
  `GWCH_ASSERT_NXT(a_load_continues, in_valid && in_ready && !in_point_last, in_ready)
  // a vertex other than the last means the walk is still running
  `GWCH_ASSERT_IMP(a_walk_busy, out_valid && !out_hull_last, !in_ready)

endmodule

bind gift_wrap_convex_hull_unit gwch_chk u_gwch_chk (.*);
